>>> sv/bcpa_pkg.sv
`timescale 1ns / 1ps
package bcpa_pkg;
    localparam int unsigned PAGES_DEF = 16;
    localparam int unsigned WORDS_DEF = 8;
    localparam int unsigned CHUNK_DEF = 64;

    typedef enum logic [2:0] {
        ST_GRANTED     = 3'd0,
        ST_FALLBACK    = 3'd1,
        ST_FREED       = 3'd2,
        ST_NOT_IN_POOL = 3'd3,
        ST_DOUBLE_FREE = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    typedef enum logic [0:0] {
        CFG_ENABLE = 1'b0,
        CFG_BASE   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [0:0]  req_type;
        logic [31:0] alloc_size;
        logic [31:0] address;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] chunk_address;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_WORD,
        S_FREAD,
        S_FMOD,
        S_OUT
    } t_state;
endpackage

>>> sv/bitmap_chunk_pool_allocator.sv
`timescale 1ns / 1ps
// Bitmap chunk pool allocator.
// Input channel: i_in_valid / o_in_stall carry a t_in request (allocate or
// free). Output channel: o_out_valid / i_out_stall carry one t_out result per
// request. A transfer happens on a rising edge with valid high and stall low.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 is pool_enable, index 1 is pool_base. Write only while idle.
// Steps from the request transfer to the result transfer (with no receiver
// stall, the next request can transfer on the same edge as the result):
//   free: address decode and bitmap read, modify/write, result.
//   allocate: page scan over the per-page summary registers at one page per
//   cycle (a full scan when a fresh page must be activated), then a read
//   and a check per bitmap word until a non-full word is found or the last
//   word of the page is checked, then the result is loaded. An allocate that
//   falls back at once (pool disabled, size too large) goes straight to the result.
// One request is in flight at a time; the state machine sets that.
// Reset clears page_active and the page counters at once. Bitmap words carry
// a valid bit per row, so a word of an inactive-since-reset row reads as zero;
// no clearing pass is needed.
// When the receiver stalls, the result is held in the output register and no
// new request is taken until it transfers.
module bitmap_chunk_pool_allocator #(
    parameter int unsigned PAGES          = bcpa_pkg::PAGES_DEF,
    parameter int unsigned WORDS_PER_PAGE = bcpa_pkg::WORDS_DEF,
    parameter int unsigned CHUNK_BYTES    = bcpa_pkg::CHUNK_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  bcpa_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output bcpa_pkg::t_out  o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [0:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data
);
    localparam int unsigned DEPTH   = PAGES * WORDS_PER_PAGE;
    localparam int unsigned PW      = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int unsigned WW      = (WORDS_PER_PAGE > 1) ? $clog2(WORDS_PER_PAGE) : 1;
    localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CPP     = WORDS_PER_PAGE * 32;
    localparam int unsigned CW      = $clog2(CPP + 1);
    localparam int unsigned CBW     = $clog2(CHUNK_BYTES);
    localparam longint unsigned PAGE_BYTES = longint'(CPP) * longint'(CHUNK_BYTES);
    localparam longint unsigned POOL_BYTES = PAGE_BYTES * longint'(PAGES);

    bcpa_pkg::t_state r_state, n_state;

    logic                r_enable;
    logic [31:0]         r_base;
    bcpa_pkg::t_in       r_req;
    bcpa_pkg::t_out      r_out;
    logic                r_out_valid;

    logic [PAGES-1:0]    r_active;
    logic [CW-1:0]       r_cnt [PAGES];
    logic [DEPTH-1:0]    r_wvalid;
    logic [31:0]         r_mem [DEPTH];
    logic [31:0]         r_rdata;

    logic [PW-1:0]       r_page;
    logic [WW-1:0]       r_word;
    logic [4:0]          r_bit;
    logic [PW:0]         r_scan;
    logic                r_inact_found;
    logic [PW-1:0]       r_inact;
    logic [31:0]         r_off;

    // Memory port controls.
    logic                mem_re, mem_we;
    logic [AW-1:0]       mem_ra, mem_wa;
    logic [31:0]         mem_wd;
    logic                rd_valid_q;

    logic                in_xfer, out_xfer;
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    // Take a new request on the edge where the held result leaves.
    assign o_in_stall  = (r_state != bcpa_pkg::S_IDLE) || (r_out_valid && i_out_stall);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    function automatic logic [AW-1:0] row(input logic [PW-1:0] p, input logic [WW-1:0] w);
        logic [AW+PW+WW:0] t;
        t = (AW+PW+WW+1)'(p) * (AW+PW+WW+1)'(WORDS_PER_PAGE) + (AW+PW+WW+1)'(w);
        return t[AW-1:0];
    endfunction

    // Free address decode, from registered offset.
    logic [31:0] off_chunk;
    logic [PW-1:0] f_page;
    logic [WW-1:0] f_word;
    logic [4:0]    f_bit;
    logic          f_inrange;
    logic [31:0]   f_pg32, f_rem;
    assign off_chunk = r_off >> CBW;
    assign f_inrange = 64'(r_off) < POOL_BYTES;
    assign f_pg32    = off_chunk / CPP;
    assign f_rem     = off_chunk % CPP;
    assign f_page    = f_pg32[PW-1:0];
    assign f_word    = WW'(f_rem >> 5);
    assign f_bit     = f_rem[4:0];

    // Memory word as seen: invalid rows read zero.
    logic [31:0] rword;
    assign rword = rd_valid_q ? r_rdata : 32'd0;

    logic [4:0] low_clear;
    always_comb begin
        low_clear = 5'd31;
        for (int b = 31; b >= 0; b--) begin
            if (!rword[b]) low_clear = 5'(b);
        end
    end

    // Grant address: base + chunk * CHUNK_BYTES, modulo 2^32.
    logic [31:0] g_chunk, g_addr;
    assign g_chunk = 32'(r_page) * 32'(CPP) + 32'(r_word) * 32'd32 + 32'(low_clear);
    assign g_addr  = r_base + (g_chunk << CBW);

    logic [PW-1:0] scan_p;
    assign scan_p = r_scan[PW-1:0];

    always_comb begin
        n_state = r_state;
        mem_re  = 1'b0;
        mem_ra  = row(r_page, r_word);
        case (r_state)
            bcpa_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_in_data.req_type == bcpa_pkg::REQ_ALLOC)
                        ? bcpa_pkg::S_SCAN : bcpa_pkg::S_FREAD;
                end
            end
            bcpa_pkg::S_SCAN: begin
                if (r_req.req_type == bcpa_pkg::REQ_ALLOC &&
                    (!r_enable || r_req.alloc_size > 32'(CHUNK_BYTES))) begin
                    n_state = bcpa_pkg::S_OUT;
                end else if (32'(r_scan) == 32'(PAGES)) begin
                    n_state = r_inact_found ? bcpa_pkg::S_READ : bcpa_pkg::S_OUT;
                end else if (r_active[scan_p] && r_cnt[scan_p] != '0) begin
                    n_state = bcpa_pkg::S_READ;
                end
            end
            bcpa_pkg::S_READ: begin
                mem_re  = 1'b1;
                n_state = bcpa_pkg::S_WORD;
            end
            bcpa_pkg::S_WORD: begin
                if (rword == 32'hFFFF_FFFF) begin
                    if (32'(r_word) == 32'(WORDS_PER_PAGE - 1)) n_state = bcpa_pkg::S_OUT;
                    else n_state = bcpa_pkg::S_READ;
                end else begin
                    n_state = bcpa_pkg::S_OUT;
                end
            end
            bcpa_pkg::S_FREAD: begin
                mem_re  = 1'b1;
                mem_ra  = row(f_page, f_word);
                n_state = bcpa_pkg::S_FMOD;
            end
            bcpa_pkg::S_FMOD: n_state = bcpa_pkg::S_OUT;
            bcpa_pkg::S_OUT:  n_state = bcpa_pkg::S_IDLE;
            default:          n_state = bcpa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bcpa_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // Bitmap memory, registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_valid_q <= 1'b0;
        end else if (mem_re) begin
            rd_valid_q <= r_wvalid[mem_ra];
        end
    end

    // Modify/write-back decisions. A free writes only when it is in the pool and its bit is set.
    logic [AW-1:0] f_row;
    assign f_row = row(r_page, r_word);
    always_comb begin
        mem_we = 1'b0;
        mem_wa = f_row;
        mem_wd = rword | (32'd1 << low_clear);
        if (r_state == bcpa_pkg::S_WORD && rword != 32'hFFFF_FFFF) begin
            mem_we = 1'b1;
        end else if (r_state == bcpa_pkg::S_FMOD && r_out.status == bcpa_pkg::ST_FREED
                     && rword[r_bit]) begin
            mem_we = 1'b1;
            mem_wd = rword & ~(32'd1 << r_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_base        <= '0;
            r_out_valid   <= 1'b0;
            r_active      <= '0;
            r_wvalid      <= '0;
            r_inact_found <= 1'b0;
            for (int p = 0; p < PAGES; p++) r_cnt[p] <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == bcpa_pkg::CFG_ENABLE) r_enable <= i_cfg_data[0];
                else                                     r_base   <= i_cfg_data;
            end
            if (out_xfer) r_out_valid <= 1'b0;
            if (mem_we) r_wvalid[mem_wa] <= 1'b1;
            case (r_state)
                bcpa_pkg::S_IDLE: begin
                    if (in_xfer) begin
                        r_req         <= i_in_data;
                        r_scan        <= '0;
                        r_word        <= '0;
                        r_inact_found <= 1'b0;
                        r_off         <= i_in_data.address - r_base;
                        r_out.chunk_address <= '0;
                        r_out.status  <= bcpa_pkg::ST_FALLBACK;
                    end
                end
                bcpa_pkg::S_SCAN: begin
                    if (!r_enable || r_req.alloc_size > 32'(CHUNK_BYTES)) begin
                        r_out.status <= bcpa_pkg::ST_FALLBACK;
                    end else if (32'(r_scan) == 32'(PAGES)) begin
                        if (r_inact_found) begin
                            r_page <= r_inact;
                            r_active[r_inact] <= 1'b1;
                            r_cnt[r_inact]    <= CW'(CPP);
                        end
                    end else if (r_active[scan_p] && r_cnt[scan_p] != '0) begin
                        r_page <= scan_p;
                    end else begin
                        if (!r_active[scan_p] && !r_inact_found) begin
                            r_inact_found <= 1'b1;
                            r_inact       <= scan_p;
                        end
                        r_scan <= r_scan + 1'b1;
                    end
                end
                bcpa_pkg::S_WORD: begin
                    if (rword != 32'hFFFF_FFFF) begin
                        r_out.status        <= bcpa_pkg::ST_GRANTED;
                        r_out.chunk_address <= g_addr;
                        if (r_cnt[r_page] != '0) r_cnt[r_page] <= r_cnt[r_page] - 1'b1;
                    end else if (32'(r_word) != 32'(WORDS_PER_PAGE - 1)) begin
                        r_word <= r_word + 1'b1;
                    end
                end
                bcpa_pkg::S_FREAD: begin
                    r_page <= f_page;
                    r_word <= f_word;
                    r_bit  <= f_bit;
                    if (!r_enable || !f_inrange || !r_active[f_page]) begin
                        r_out.status <= bcpa_pkg::ST_NOT_IN_POOL;
                    end else begin
                        r_out.status <= bcpa_pkg::ST_FREED;
                    end
                end
                bcpa_pkg::S_FMOD: begin
                    if (r_out.status == bcpa_pkg::ST_FREED) begin
                        if (!rword[r_bit]) begin
                            r_out.status <= bcpa_pkg::ST_DOUBLE_FREE;
                        end else if (32'(r_cnt[r_page]) < 32'(CPP)) begin
                            r_cnt[r_page] <= r_cnt[r_page] + 1'b1;
                        end
                    end
                end
                bcpa_pkg::S_OUT: r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule
